### hw/rtl/estm_pkg.sv
// Shared types, constants and functions for the scaled Euler matrix core.
// Holds the input/output word structs, the quarter-wave sine table and rounding helpers.
// Depends on nothing.
package estm_pkg;

  localparam int ANG_W     = 12;
  localparam int IDX_W     = 11;
  localparam int SIN_DEPTH = 1025;
  localparam int QUARTER   = 1024;
  localparam int TRIG_W    = 16;
  localparam int PAIR_W    = 32;
  localparam int TRIPLE_W  = 48;
  localparam int ENT_W     = 46;
  localparam int SCALE_W   = 16;
  localparam int PROD_W    = ENT_W + SCALE_W;
  localparam int NUM_ENT   = 9;
  localparam int Q14_SH    = 14;
  localparam int Q28_SH    = 28;
  localparam int DROP_SH   = 34;
  localparam int NUM_STG   = 6;

  localparam logic [63:0] Q60_PI = 64'h3243F6A8885A308D;
  localparam logic signed [63:0] MAX32 = 64'sd2147483647;
  localparam logic signed [63:0] MIN32 = -64'sd2147483648;
  localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W+1)'(64'd1 << (DROP_SH - 1));

  typedef struct packed {
    logic        [11:0] angle_x;
    logic        [11:0] angle_y;
    logic        [11:0] angle_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] c0_x;
    logic signed [31:0] c0_y;
    logic signed [31:0] c0_z;
    logic signed [31:0] c1_x;
    logic signed [31:0] c1_y;
    logic signed [31:0] c1_z;
    logic signed [31:0] c2_x;
    logic signed [31:0] c2_y;
    logic signed [31:0] c2_z;
    logic signed [31:0] out_tx;
    logic signed [31:0] out_ty;
    logic signed [31:0] out_tz;
  } out_word_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sx;
    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sz;
    logic signed [TRIG_W-1:0] cz;
  } trig_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0] scale_x;
    logic signed [SCALE_W-1:0] scale_y;
    logic signed [SCALE_W-1:0] scale_z;
    logic signed [31:0]        tx;
    logic signed [31:0]        ty;
    logic signed [31:0]        tz;
  } side_t;

  typedef struct packed {
    logic ang;
    logic trig;
    logic pair;
    logic ent;
    logic prod;
    logic outw;
  } pipe_en_t;

  typedef logic signed [PROD_W-1:0] prod_arr_t [NUM_ENT];
  typedef logic [14:0] sin_tab_t [SIN_DEPTH];

  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] div;
    logic [63:0] v;
    for (int k = 0; k < SIN_DEPTH; k++) begin
      x = (Q60_PI >> 11) * 64'(k) + (((Q60_PI & 64'h7FF) * 64'(k)) >> 11);
      x2 = mul_q60(x, x);
      term = x;
      sum = x;
      for (int n = 1; n <= 14; n++) begin
        div = 64'((2 * n) * (2 * n + 1));
        term = udiv64(mul_q60(term, x2), div);
        if ((n % 2) == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
      v = (sum + (64'd1 << 45)) >> 46;
      tab[k] = v[14:0];
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > MAX32) begin
      return MAX32[31:0];
    end else if (v < MIN32) begin
      return MIN32[31:0];
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] round_q16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W:0] s;
    s = (PROD_W+1)'(p) + ROUND_HALF;
    return sat32(64'(s >>> DROP_SH));
  endfunction

endpackage

### hw/rtl/estm_sincos.sv
// Sine/cosine lookup: folds six angles to quarter-wave indexes, then reads the table.
// Two register stages. Depends on estm_pkg.
module estm_sincos import estm_pkg::*; (
  input  logic     clk,
  input  pipe_en_t en,
  input  in_word_t in_word,
  output trig_t    trig_r
);

  logic [ANG_W-1:0]         ang [6];
  logic [IDX_W-1:0]         idx_nxt [6];
  logic                     neg_nxt [6];
  logic [IDX_W-1:0]         idx_r [6];
  logic                     neg_r [6];
  logic signed [TRIG_W-1:0] mag [6];
  logic signed [TRIG_W-1:0] val [6];
  trig_t                    trig_nxt;

  always_comb begin
    ang[0] = in_word.angle_x;
    ang[1] = in_word.angle_x + ANG_W'(QUARTER);
    ang[2] = in_word.angle_y;
    ang[3] = in_word.angle_y + ANG_W'(QUARTER);
    ang[4] = in_word.angle_z;
    ang[5] = in_word.angle_z + ANG_W'(QUARTER);
    for (int i = 0; i < 6; i++) begin
      idx_nxt[i] = ang[i][10] ? (IDX_W'(QUARTER) - {1'b0, ang[i][9:0]}) : {1'b0, ang[i][9:0]};
      neg_nxt[i] = ang[i][11];
    end
  end

  always_ff @(posedge clk) begin
    if (en.ang) begin
      for (int i = 0; i < 6; i++) begin
        idx_r[i] <= idx_nxt[i];
        neg_r[i] <= neg_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      mag[i] = TRIG_W'({1'b0, SIN_TAB[idx_r[i]]});
      val[i] = neg_r[i] ? -mag[i] : mag[i];
    end
    trig_nxt.sx = val[0];
    trig_nxt.cx = val[1];
    trig_nxt.sy = val[2];
    trig_nxt.cy = val[3];
    trig_nxt.sz = val[4];
    trig_nxt.cz = val[5];
  end

  always_ff @(posedge clk) begin
    if (en.trig) begin
      trig_r <= trig_nxt;
    end
  end

endmodule

### hw/rtl/estm_mat.sv
// Matrix product stages: pair products, Q42 entries, then scaling by the column scale.
// Three register stages. Depends on estm_pkg.
module estm_mat import estm_pkg::*; (
  input  logic      clk,
  input  pipe_en_t  en,
  input  trig_t     trig,
  input  side_t     side_ent,
  output prod_arr_t prod_r
);

  typedef struct packed {
    logic signed [PAIR_W-1:0] cycz;
    logic signed [PAIR_W-1:0] sysx;
    logic signed [PAIR_W-1:0] cysx;
    logic signed [PAIR_W-1:0] cysz;
    logic signed [PAIR_W-1:0] cxsz;
    logic signed [PAIR_W-1:0] cxcz;
    logic signed [PAIR_W-1:0] sysz;
    logic signed [PAIR_W-1:0] cxsy;
    logic signed [PAIR_W-1:0] cycx;
    logic signed [PAIR_W-1:0] czsy;
    logic signed [TRIG_W-1:0] sx;
    logic signed [TRIG_W-1:0] sz;
    logic signed [TRIG_W-1:0] cz;
  } pair_t;

  pair_t                      pair_nxt;
  pair_t                      pair_r;
  logic signed [TRIPLE_W-1:0] m0;
  logic signed [TRIPLE_W-1:0] m1;
  logic signed [TRIPLE_W-1:0] m2;
  logic signed [TRIPLE_W-1:0] m3;
  logic signed [ENT_W-1:0]    ent_nxt [NUM_ENT];
  logic signed [ENT_W-1:0]    ent_r [NUM_ENT];
  prod_arr_t                  prod_nxt;

  always_comb begin
    pair_nxt.cycz = trig.cy * trig.cz;
    pair_nxt.sysx = trig.sy * trig.sx;
    pair_nxt.cysx = trig.cy * trig.sx;
    pair_nxt.cysz = trig.cy * trig.sz;
    pair_nxt.cxsz = trig.cx * trig.sz;
    pair_nxt.cxcz = trig.cx * trig.cz;
    pair_nxt.sysz = trig.sy * trig.sz;
    pair_nxt.cxsy = trig.cx * trig.sy;
    pair_nxt.cycx = trig.cy * trig.cx;
    pair_nxt.czsy = trig.cz * trig.sy;
    pair_nxt.sx   = trig.sx;
    pair_nxt.sz   = trig.sz;
    pair_nxt.cz   = trig.cz;
  end

  always_ff @(posedge clk) begin
    if (en.pair) begin
      pair_r <= pair_nxt;
    end
  end

  assign m0 = pair_r.sysx * pair_r.sz;
  assign m1 = pair_r.cysx * pair_r.sz;
  assign m2 = pair_r.sysx * pair_r.cz;
  assign m3 = pair_r.cycz * pair_r.sx;

  always_comb begin
    ent_nxt[0] = (ENT_W'(pair_r.cycz) <<< Q14_SH) + ENT_W'(m0);
    ent_nxt[1] = ENT_W'(pair_r.cxsz) <<< Q14_SH;
    ent_nxt[2] = ENT_W'(m1) - (ENT_W'(pair_r.czsy) <<< Q14_SH);
    ent_nxt[3] = ENT_W'(m2) - (ENT_W'(pair_r.cysz) <<< Q14_SH);
    ent_nxt[4] = ENT_W'(pair_r.cxcz) <<< Q14_SH;
    ent_nxt[5] = ENT_W'(m3) + (ENT_W'(pair_r.sysz) <<< Q14_SH);
    ent_nxt[6] = ENT_W'(pair_r.cxsy) <<< Q14_SH;
    ent_nxt[7] = -(ENT_W'(pair_r.sx) <<< Q28_SH);
    ent_nxt[8] = ENT_W'(pair_r.cycx) <<< Q14_SH;
  end

  always_ff @(posedge clk) begin
    if (en.ent) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        ent_r[i] <= ent_nxt[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i]     = ent_r[i] * side_ent.scale_x;
      prod_nxt[i + 3] = ent_r[i + 3] * side_ent.scale_y;
      prod_nxt[i + 6] = ent_r[i + 6] * side_ent.scale_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en.prod) begin
      for (int i = 0; i < NUM_ENT; i++) begin
        prod_r[i] <= prod_nxt[i];
      end
    end
  end

endmodule

### hw/rtl/estm_round.sv
// Output stage: rounds the scaled entries half up to Q16.16, saturates, packs the word.
// One register stage. Depends on estm_pkg.
module estm_round import estm_pkg::*; (
  input  logic      clk,
  input  pipe_en_t  en,
  input  prod_arr_t prod,
  input  side_t     side_out,
  output out_word_t out_word_r
);

  out_word_t out_nxt;

  always_comb begin
    out_nxt.c0_x   = round_q16(prod[0]);
    out_nxt.c0_y   = round_q16(prod[1]);
    out_nxt.c0_z   = round_q16(prod[2]);
    out_nxt.c1_x   = round_q16(prod[3]);
    out_nxt.c1_y   = round_q16(prod[4]);
    out_nxt.c1_z   = round_q16(prod[5]);
    out_nxt.c2_x   = round_q16(prod[6]);
    out_nxt.c2_y   = round_q16(prod[7]);
    out_nxt.c2_z   = round_q16(prod[8]);
    out_nxt.out_tx = side_out.tx;
    out_nxt.out_ty = side_out.ty;
    out_nxt.out_tz = side_out.tz;
  end

  always_ff @(posedge clk) begin
    if (en.outw) begin
      out_word_r <= out_nxt;
    end
  end

endmodule

### hw/rtl/euler_scale_translate_matrix_core.sv
// Top level of the scaled Y-X-Z Euler matrix core with translation.
// Depends on estm_pkg, estm_sincos, estm_mat, estm_round.
//
//   channel   handshake              word
//   in        in_valid / in_ready    in_word  (in_word_t: angles, scales, translation)
//   out       out_valid / out_ready  out_word (out_word_t: 3x3 columns, translation)
//
// Six register stages: angle fold, sine table read, pair products, Q42 entries,
// scale products, round and pack. One word per cycle is sustained while out_ready stays high.
// Each stage advances when it is empty or the stage after it advances, so bubbles
// collapse under a stall. Synchronous active-low reset clears the valid bits only.
module euler_scale_translate_matrix_core import estm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_word
);

  logic [NUM_STG-1:0] vld_r;
  logic [NUM_STG-1:0] vld_nxt;
  logic [NUM_STG-1:0] adv;
  pipe_en_t           en;
  side_t              side_nxt;
  side_t              side_r [NUM_STG-1];
  trig_t              trig;
  prod_arr_t          prod;

  always_comb begin
    adv[NUM_STG-1] = !vld_r[NUM_STG-1] || out_ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k + 1];
    end
  end

  assign en.ang  = adv[0];
  assign en.trig = adv[1];
  assign en.pair = adv[2];
  assign en.ent  = adv[3];
  assign en.prod = adv[4];
  assign en.outw = adv[5];

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NUM_STG-1];

  always_comb begin
    vld_nxt = vld_r;
    if (adv[0]) begin
      vld_nxt[0] = in_valid;
    end
    for (int k = 1; k < NUM_STG; k++) begin
      if (adv[k]) begin
        vld_nxt[k] = vld_r[k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    side_nxt.scale_x = in_word.scale_x;
    side_nxt.scale_y = in_word.scale_y;
    side_nxt.scale_z = in_word.scale_z;
    side_nxt.tx      = in_word.trans_x;
    side_nxt.ty      = sat32(-(64'(in_word.trans_y)));
    side_nxt.tz      = in_word.trans_z;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      side_r[0] <= side_nxt;
    end
    for (int k = 1; k < NUM_STG - 1; k++) begin
      if (adv[k]) begin
        side_r[k] <= side_r[k - 1];
      end
    end
  end

  estm_sincos u_sincos (
    .clk     (clk),
    .en      (en),
    .in_word (in_word),
    .trig_r  (trig)
  );

  estm_mat u_mat (
    .clk      (clk),
    .en       (en),
    .trig     (trig),
    .side_ent (side_r[3]),
    .prod_r   (prod)
  );

  estm_round u_round (
    .clk        (clk),
    .en         (en),
    .prod       (prod),
    .side_out   (side_r[4]),
    .out_word_r (out_word)
  );

`ifndef SYNTHESIS
  a_empty_out_takes_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked while output stage is empty");

  a_full_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r) && !out_ready |-> !in_ready)
    else $error("input taken while every stage is full and stalled");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted word missing from first stage");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

### dv/tb_top.sv
// Self-checking bench for euler_scale_translate_matrix_core: a directed table, then random words.
// Words with no given result are predicted by a local fixed-point model; needs estm_pkg and the DUT.
module tb_top;
  import estm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 1250;
  localparam int OUT_BITS = $bits(out_word_t);
  localparam int FIELD_CNT = 12;

  typedef struct packed {
    in_word_t  stim;
    logic      known;
    out_word_t want;
  } vec_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  int        quarter_sine [0:1024];
  out_word_t pending_mats [$];
  vec_t      dir_vecs [$];
  int        mismatch_cnt = 0;
  string     field_name [FIELD_CNT] = '{"c0_x", "c0_y", "c0_z", "c1_x", "c1_y", "c1_z",
                                        "c2_x", "c2_y", "c2_z", "out_tx", "out_ty", "out_tz"};

  euler_scale_translate_matrix_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void build_quarter_sine();
    logic [63:0]  pi_q60;
    logic [63:0]  x;
    logic [63:0]  x2;
    logic [63:0]  term;
    logic [63:0]  acc;
    logic [127:0] wide;
    pi_q60 = 64'h3243F6A8885A308D;
    for (int k = 0; k < 1025; k++) begin
      x = (pi_q60 >> 11) * 64'(k) + (((pi_q60 & 64'h7FF) * 64'(k)) >> 11);
      wide = 128'(x) * 128'(x);
      x2 = wide[123:60];
      term = x;
      acc = x;
      for (int n = 1; n <= 14; n++) begin
        wide = 128'(term) * 128'(x2);
        term = wide[123:60] / 64'((2 * n) * (2 * n + 1));
        acc = (n % 2 == 1) ? acc - term : acc + term;
      end
      quarter_sine[k] = int'((acc + (64'd1 << 45)) >> 46);
    end
  endfunction

  function automatic longint trig_q14(logic [11:0] a);
    longint v;
    v = a[10] ? quarter_sine[1024 - a[9:0]] : quarter_sine[a[9:0]];
    return a[11] ? -v : v;
  endfunction

  function automatic logic [31:0] to_q16(longint q42, longint k);
    longint p;
    longint r;
    p = q42 * k + (longint'(1) << 33);
    r = p >>> 34;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic out_word_t euler_transform(in_word_t w);
    longint    sx, cx, sy, cy, sz, cz, kx, ky, kz, ty;
    longint    p14, p28;
    out_word_t r;
    p14 = 64'sd16384;
    p28 = 64'sd268435456;
    sx = trig_q14(w.angle_x);
    cx = trig_q14(12'(w.angle_x + 12'd1024));
    sy = trig_q14(w.angle_y);
    cy = trig_q14(12'(w.angle_y + 12'd1024));
    sz = trig_q14(w.angle_z);
    cz = trig_q14(12'(w.angle_z + 12'd1024));
    kx = longint'(w.scale_x);
    ky = longint'(w.scale_y);
    kz = longint'(w.scale_z);
    r.c0_x = to_q16(cy * cz * p14 + sy * sx * sz, kx);
    r.c0_y = to_q16(cx * sz * p14, kx);
    r.c0_z = to_q16(cy * sx * sz - cz * sy * p14, kx);
    r.c1_x = to_q16(cz * sy * sx - cy * sz * p14, ky);
    r.c1_y = to_q16(cx * cz * p14, ky);
    r.c1_z = to_q16(cy * cz * sx + sy * sz * p14, ky);
    r.c2_x = to_q16(cx * sy * p14, kz);
    r.c2_y = to_q16(-sx * p28, kz);
    r.c2_z = to_q16(cy * cx * p14, kz);
    ty = -longint'(w.trans_y);
    if (ty > 64'sd2147483647) ty = 64'sd2147483647;
    r.out_tx = w.trans_x;
    r.out_ty = ty[31:0];
    r.out_tz = w.trans_z;
    return r;
  endfunction

  function automatic in_word_t pack_in(int ax, int ay, int az, int kx, int ky, int kz,
                                       int tx, int ty, int tz);
    in_word_t r;
    r.angle_x = 12'(ax);
    r.angle_y = 12'(ay);
    r.angle_z = 12'(az);
    r.scale_x = 16'(kx);
    r.scale_y = 16'(ky);
    r.scale_z = 16'(kz);
    r.trans_x = tx;
    r.trans_y = ty;
    r.trans_z = tz;
    return r;
  endfunction

  function automatic out_word_t pack_out(int a0, int a1, int a2, int b0, int b1, int b2,
                                         int d0, int d1, int d2, int tx, int ty, int tz);
    out_word_t r;
    r = {a0, a1, a2, b0, b1, b2, d0, d1, d2, tx, ty, tz};
    return r;
  endfunction

  function automatic logic [11:0] pick_angle();
    case ($urandom_range(0, 7))
      0: return 12'($urandom_range(0, 3) * 1024);
      1: return 12'($urandom_range(1, 4) * 1024 - 1);
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_scale();
    case ($urandom_range(0, 15))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0100;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_trans();
    case ($urandom_range(0, 15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'($urandom);
    endcase
  endfunction

  task automatic add_vec(input in_word_t w, input logic known, input out_word_t want);
    vec_t v;
    v.stim = w;
    v.known = known;
    v.want = want;
    dir_vecs = {dir_vecs, v};
  endtask

  task automatic send_word(input in_word_t w, input logic known, input out_word_t want,
                           input int gap);
    out_word_t exp_w;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    exp_w = known ? want : euler_transform(w);
    pending_mats = {pending_mats, exp_w};
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_mats.size() != 0);
  endtask

  initial begin
    in_word_t w;
    logic     burst;
    int       gap;
    build_quarter_sine();

    add_vec(pack_in(0, 0, 0, 256, 256, 256, 32'h12345678, 32'h00010000, -65536), 1'b1,
            pack_out(65536, 0, 0, 0, 65536, 0, 0, 0, 65536, 32'h12345678, -65536, -65536));
    add_vec(pack_in(0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h80000000), 1'b1,
            pack_out(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000));
    add_vec(pack_in(0, 0, 0, -32768, -32768, -32768, 32'h80000000, 32'h7FFFFFFF,
                    32'h7FFFFFFF), 1'b1,
            pack_out(-8388608, 0, 0, 0, -8388608, 0, 0, 0, -8388608, 32'h80000000,
                     32'h80000001, 32'h7FFFFFFF));
    add_vec(pack_in(0, 0, 0, 32767, 32767, 32767, -1, 1, 0), 1'b1,
            pack_out(8388352, 0, 0, 0, 8388352, 0, 0, 0, 8388352, -1, -1, 0));
    add_vec(pack_in(1024, 0, 0, 256, 256, 256, 0, 0, 0), 1'b1,
            pack_out(65536, 0, 0, 0, 0, 65536, 0, -65536, 0, 0, 0, 0));
    add_vec(pack_in(0, 1024, 0, 256, 256, 256, 0, 0, 0), 1'b1,
            pack_out(0, 0, -65536, 0, 65536, 0, 65536, 0, 0, 0, 0, 0));
    add_vec(pack_in(0, 0, 1024, 256, 256, 256, 5, 6, 7), 1'b0, '0);
    add_vec(pack_in(2048, 0, 0, 256, -256, 512, 1, -1, 2), 1'b0, '0);
    add_vec(pack_in(3072, 3072, 3072, 256, 256, 256, 0, 0, 0), 1'b0, '0);
    add_vec(pack_in(4095, 4095, 4095, -32768, 32767, -1, -1, -1, -1), 1'b0, '0);
    add_vec(pack_in(2047, 2049, 1023, 32767, -32768, 1, 32'h7FFFFFFF, 32'h7FFFFFFF,
                    32'h80000000), 1'b0, '0);
    add_vec(pack_in(1025, 3071, 3073, -256, 256, -1, 100, -100, 0), 1'b0, '0);
    add_vec(pack_in(512, 512, 512, 256, 256, 256, 0, 0, 0), 1'b0, '0);
    add_vec(pack_in(1, 4094, 2, 255, -255, 16'h00FF, 0, 0, 0), 1'b0, '0);
    add_vec(pack_in(0, 0, 0, -1, -1, -1, 0, 0, 0), 1'b0, '0);
    add_vec(pack_in(0, 0, 0, 1, 1, 1, 0, 0, 0), 1'b0, '0);
    add_vec(pack_in(341, 1365, 2731, 12345, -23456, 777, 32'hDEADBEEF, 32'hCAFEF00D,
                    32'h0BADF00D), 1'b0, '0);
    add_vec(pack_in(4095, 0, 2048, 16'h5555, 16'hAAAA, 16'h7FFF, 32'h55555555, 32'hAAAAAAAA,
                    32'h55555555), 1'b0, '0);
    add_vec(pack_in(12'hAAA, 12'h555, 12'hFFF, 16'hAAAA, 16'h5555, 16'h8000, 32'hAAAAAAAA,
                    32'h55555555, 32'hAAAAAAAA), 1'b0, '0);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_vecs[i]) begin
      send_word(dir_vecs[i].stim, dir_vecs[i].known, dir_vecs[i].want, $urandom_range(0, 18));
    end

    burst = 1'b0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 400 == 0) drain_pipe();
      if (i % 64 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 18);
      w.angle_x = pick_angle();
      w.angle_y = pick_angle();
      w.angle_z = pick_angle();
      w.scale_x = pick_scale();
      w.scale_y = pick_scale();
      w.scale_z = pick_scale();
      w.trans_x = pick_trans();
      w.trans_y = pick_trans();
      w.trans_z = pick_trans();
      send_word(w, 1'b0, '0, gap);
    end

    drain_pipe();
    repeat (12) @(posedge clk);
    if (mismatch_cnt == 0 && pending_mats.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    int   stall;
    logic fast_out;
    fast_out = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if ($urandom_range(0, 49) == 0) fast_out = !fast_out;
      stall = fast_out ? 0 : $urandom_range(0, 18);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_mats.size() == 0) begin
        if (mismatch_cnt < 10) $display("unexpected word: %h", out_word);
        mismatch_cnt++;
      end else begin
        want = pending_mats.pop_front();
        for (int f = 0; f < FIELD_CNT; f++) begin
          if (out_word[OUT_BITS-1-32*f -: 32] !== want[OUT_BITS-1-32*f -: 32]) begin
            if (mismatch_cnt < 10) begin
              $display("mismatch %0s: expected %08h got %08h", field_name[f],
                       want[OUT_BITS-1-32*f -: 32], out_word[OUT_BITS-1-32*f -: 32]);
            end
            mismatch_cnt++;
          end
        end
      end
    end
  end

endmodule

### sim.f
hw/rtl/estm_pkg.sv
hw/rtl/estm_sincos.sv
hw/rtl/estm_mat.sv
hw/rtl/estm_round.sv
hw/rtl/euler_scale_translate_matrix_core.sv
dv/tb_top.sv
